[hdl/http_status_line_parser_macros.svh]
// Assertion macros shared by the status line parser RTL.
`ifndef HTTP_STATUS_LINE_PARSER_MACROS_SVH
`define HTTP_STATUS_LINE_PARSER_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define HSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define HSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/hsl_pkg.sv]
// Package with constants, types and helpers of the status line parser.
`timescale 1ns / 1ps
package hsl_pkg;

  localparam int MAX_REASON_LEN = 64;
  localparam int VERSION_DIGITS = 2;
  localparam int CODE_DIGITS    = 3;

  localparam int BYTE_W  = 8;
  localparam int PHASE_W = 3;
  localparam int VER_W   = 7;
  localparam int CODE_W  = 10;
  localparam int RIDX_W  = 6;
  localparam int POS_W   = $clog2(MAX_REASON_LEN + 1) > 3 ? $clog2(MAX_REASON_LEN + 1) : 3;

  localparam int PREFIX_LEN  = 5;
  localparam int VERSION_CAP = 127;

  localparam logic [BYTE_W-1:0] CHAR_H     = 8'h48;
  localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;
  localparam logic [BYTE_W-1:0] CHAR_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_HTAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7F;

  typedef enum logic [PHASE_W-1:0] {
    PH_PREFIX = 3'd0,
    PH_MAJOR  = 3'd1,
    PH_MINOR  = 3'd2,
    PH_CODE   = 3'd3,
    PH_REASON = 3'd4,
    PH_LF     = 3'd5,
    PH_DONE   = 3'd6,
    PH_ERROR  = 3'd7
  } phase_t;

  // Expected character of the literal "HTTP/" at a given position.
  function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      3'd0:    c = CHAR_H;
      3'd1:    c = CHAR_T;
      3'd2:    c = CHAR_T;
      3'd3:    c = CHAR_P;
      3'd4:    c = CHAR_SLASH;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic is_dec_char(input logic [BYTE_W-1:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  // HTAB, space, visible ASCII and any byte with the top bit set.
  function automatic logic is_reason_char(input logic [BYTE_W-1:0] b);
    return (b == CHAR_HTAB) || ((b >= CHAR_SPACE) && (b <= CHAR_TILDE)) || (b > CHAR_DEL);
  endfunction

endpackage

[hdl/hsl_stream_if.sv]
// Valid/ready channel interfaces for the parser input and result words.
`timescale 1ns / 1ps
interface hsl_in_if;
  import hsl_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              restart;

  modport source (output valid, output byte_in, output restart, input ready);
  modport sink   (input valid, input byte_in, input restart, output ready);
endinterface

interface hsl_out_if;
  import hsl_pkg::*;
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] parse_phase;
  logic [VER_W-1:0]   major_ver;
  logic [VER_W-1:0]   minor_ver;
  logic [CODE_W-1:0]  resp_code;
  logic               reason_valid;
  logic [BYTE_W-1:0]  reason_byte;
  logic [RIDX_W-1:0]  reason_index;

  modport source (output valid, output parse_phase, output major_ver,
                  output minor_ver, output resp_code, output reason_valid,
                  output reason_byte, output reason_index, input ready);
  modport sink   (input valid, input parse_phase, input major_ver,
                  input minor_ver, input resp_code, input reason_valid,
                  input reason_byte, input reason_index, output ready);
endinterface

[hdl/http_status_line_parser.sv]
// HTTP/1.1 status line parser, one byte per word, top level.
// The input channel in_ch carries one byte of a response status line per word
// together with a restart flag; restart puts the parser back to the start of
// the line before that byte is parsed. The result channel out_ch returns one
// word per input word: the parse phase after the byte, the major and minor
// version and the status code decoded so far, and, for a byte taken as part of
// the reason phrase, that byte with its position in the phrase.
// A word accepted into the input register is parsed there, and its result is
// loaded into the result register once that register can take it.
// Throughput is one word per cycle while the receiver takes results, set by
// the single phase and accumulator update between input and result register.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; after that in_ch.ready drops until
// the result is taken. Done and error phases hold until a restart.
// Synchronous active-low reset empties both registers and clears the parser
// to the prefix phase with all decoded values zero.
`timescale 1ns / 1ps
`include "http_status_line_parser_macros.svh"
module http_status_line_parser (
  input logic       clk,
  input logic       rst_n,
  hsl_in_if.sink    in_ch,
  hsl_out_if.source out_ch
);
  import hsl_pkg::*;

  // Input register stage.
  logic              s1_v_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_restart_r;

  // Parser state.
  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [VER_W-1:0]  major_r, major_nxt;
  logic [VER_W-1:0]  minor_r, minor_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;

  // Result register stage.
  logic              out_v_r;
  phase_t            out_phase_r;
  logic [VER_W-1:0]  out_major_r;
  logic [VER_W-1:0]  out_minor_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_rvalid_r, rvalid_nxt;
  logic [BYTE_W-1:0] out_rbyte_r, rbyte_nxt;
  logic [RIDX_W-1:0] out_ridx_r, ridx_nxt;

  // The result register can load when it is empty or being emptied.
  logic advance;
  logic fire;
  logic in_take;

  // State seen by the current byte, after an optional restart.
  phase_t            cur_phase;
  logic [POS_W-1:0]  cur_pos;
  logic [VER_W-1:0]  cur_major;
  logic [VER_W-1:0]  cur_minor;
  logic [CODE_W-1:0] cur_code;
  logic [3:0]        digit;

  assign advance     = !out_v_r || out_ch.ready;
  assign fire        = s1_v_r && advance;
  assign in_ch.ready = !s1_v_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign digit       = s1_byte_r[3:0];

  // First digit replaces the value, later digits accumulate; saturates.
  function automatic logic [VER_W-1:0] version_digit(input logic [VER_W-1:0] old,
                                                     input logic first,
                                                     input logic [3:0] d);
    logic [VER_W+3:0] sum;
    if (first) begin
      sum = {{VER_W{1'b0}}, d};
    end else begin
      sum = {4'b0, old} * (VER_W+4)'(10) + {{VER_W{1'b0}}, d};
    end
    return (sum > (VER_W+4)'(VERSION_CAP)) ? VER_W'(VERSION_CAP) : sum[VER_W-1:0];
  endfunction

  function automatic logic [CODE_W-1:0] code_digit(input logic [CODE_W-1:0] old,
                                                   input logic first,
                                                   input logic [3:0] d);
    logic [CODE_W+3:0] sum;
    if (first) begin
      sum = {{CODE_W{1'b0}}, d};
    end else begin
      sum = {4'b0, old} * (CODE_W+4)'(10) + {{CODE_W{1'b0}}, d};
    end
    return sum[CODE_W-1:0];
  endfunction

  always_comb begin
    if (s1_restart_r) begin
      cur_phase = PH_PREFIX;
      cur_pos   = '0;
      cur_major = '0;
      cur_minor = '0;
      cur_code  = '0;
    end else begin
      cur_phase = phase_r;
      cur_pos   = pos_r;
      cur_major = major_r;
      cur_minor = minor_r;
      cur_code  = code_r;
    end

    phase_nxt  = cur_phase;
    pos_nxt    = cur_pos;
    major_nxt  = cur_major;
    minor_nxt  = cur_minor;
    code_nxt   = cur_code;
    rvalid_nxt = 1'b0;
    rbyte_nxt  = '0;
    ridx_nxt   = '0;

    case (cur_phase)
      PH_PREFIX: begin
        if ((cur_pos >= POS_W'(PREFIX_LEN)) || (prefix_char(cur_pos[2:0]) != s1_byte_r)) begin
          phase_nxt = PH_ERROR;
        end else if (s1_byte_r == CHAR_SLASH) begin
          pos_nxt   = '0;
          phase_nxt = PH_MAJOR;
        end else begin
          pos_nxt = cur_pos + 1'b1;
        end
      end
      PH_MAJOR: begin
        // The separator is checked ahead of the digit count.
        if (s1_byte_r == CHAR_DOT) begin
          pos_nxt   = '0;
          phase_nxt = PH_MINOR;
        end else if ((cur_pos >= POS_W'(VERSION_DIGITS)) || !is_dec_char(s1_byte_r)) begin
          phase_nxt = PH_ERROR;
        end else begin
          major_nxt = version_digit(cur_major, cur_pos == '0, digit);
          pos_nxt   = cur_pos + 1'b1;
        end
      end
      PH_MINOR: begin
        if (s1_byte_r == CHAR_SPACE) begin
          pos_nxt   = '0;
          phase_nxt = PH_CODE;
        end else if ((cur_pos >= POS_W'(VERSION_DIGITS)) || !is_dec_char(s1_byte_r)) begin
          phase_nxt = PH_ERROR;
        end else begin
          minor_nxt = version_digit(cur_minor, cur_pos == '0, digit);
          pos_nxt   = cur_pos + 1'b1;
        end
      end
      PH_CODE: begin
        if (cur_pos >= POS_W'(CODE_DIGITS)) begin
          if (s1_byte_r == CHAR_SPACE) begin
            pos_nxt   = '0;
            phase_nxt = PH_REASON;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end else if (!is_dec_char(s1_byte_r)) begin
          phase_nxt = PH_ERROR;
        end else begin
          code_nxt = code_digit(cur_code, cur_pos == '0, digit);
          pos_nxt  = cur_pos + 1'b1;
        end
      end
      PH_REASON: begin
        if (s1_byte_r == CHAR_CR) begin
          pos_nxt   = '0;
          phase_nxt = PH_LF;
        end else if ((cur_pos >= POS_W'(MAX_REASON_LEN)) || !is_reason_char(s1_byte_r)) begin
          phase_nxt = PH_ERROR;
        end else begin
          rvalid_nxt = 1'b1;
          rbyte_nxt  = s1_byte_r;
          ridx_nxt   = cur_pos[RIDX_W-1:0];
          pos_nxt    = cur_pos + 1'b1;
        end
      end
      PH_LF: begin
        phase_nxt = (s1_byte_r == CHAR_LF) ? PH_DONE : PH_ERROR;
      end
      default: begin
        // Done and error hold until the next restart.
        phase_nxt = cur_phase;
      end
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_take) begin
      s1_v_r <= 1'b1;
    end else if (fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r    <= in_ch.byte_in;
      s1_restart_r <= in_ch.restart;
    end
  end

  // Parser state, updated once per parsed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      pos_r   <= '0;
      major_r <= '0;
      minor_r <= '0;
      code_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      code_r  <= code_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_phase_r  <= phase_nxt;
      out_major_r  <= major_nxt;
      out_minor_r  <= minor_nxt;
      out_code_r   <= code_nxt;
      out_rvalid_r <= rvalid_nxt;
      out_rbyte_r  <= rbyte_nxt;
      out_ridx_r   <= ridx_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.parse_phase  = out_phase_r;
  assign out_ch.major_ver    = out_major_r;
  assign out_ch.minor_ver    = out_minor_r;
  assign out_ch.resp_code    = out_code_r;
  assign out_ch.reason_valid = out_rvalid_r;
  assign out_ch.reason_byte  = out_rbyte_r;
  assign out_ch.reason_index = out_ridx_r;

  // A reason character is only reported while the phrase is being read.
  `HSL_ASSERT_NOW(a_reason_phase, out_ch.valid && out_ch.reason_valid, out_ch.parse_phase == PH_REASON, "reason byte outside reason phase")
  // Error is sticky unless the parsed word asks for a restart.
  `HSL_ASSERT_NEXT(a_error_sticky, fire && !s1_restart_r && (phase_r == PH_ERROR), phase_r == PH_ERROR, "error phase left without restart")
  // Input back-pressure only comes from a full pipeline behind a stalled result.
  `HSL_ASSERT_NOW(a_ready_cause, !in_ch.ready, s1_v_r && out_v_r && !out_ch.ready, "input stalled without a stalled result")

endmodule

[tb/testbench.sv]
// Self-checking testbench of the byte-serial HTTP status line parser.
`timescale 1ns / 1ps
module testbench;
  import hsl_pkg::*;

  // The random part stops once this many bytes have reached a live parser,
  // that is, a parser that is not already sitting in done or error.
  localparam int RANDOM_BYTES = 550;
  // Length of the one long stretch during which the result side refuses words.
  localparam int HOLD_CYCLES  = 48;

  // One result word, laid out field by field so that a whole word can be
  // compared at once and still be printed per field on a mismatch.
  typedef struct packed {
    phase_t            phase;
    logic [VER_W-1:0]  major;
    logic [VER_W-1:0]  minor;
    logic [CODE_W-1:0] code;
    logic              rvalid;
    logic [BYTE_W-1:0] rbyte;
    logic [RIDX_W-1:0] ridx;
  } status_word_t;

  // One row of the directed table. Where typed is set, the row carries the
  // result word written out by hand; otherwise the line model supplies it.
  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              rs;
    bit                typed;
    status_word_t      want;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;

  hsl_in_if  in_ch ();
  hsl_out_if out_ch ();

  http_status_line_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hard stop well beyond the slowest correct run, so a hung handshake
  // cannot keep the simulation alive.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line model: its own copy of the parser state, advanced once per accepted
  // input word.
  // ---------------------------------------------------------------------------
  phase_t            line_phase = PH_PREFIX;
  int                field_pos  = 0;
  int                major_acc  = 0;
  int                minor_acc  = 0;
  int                code_acc   = 0;
  logic [BYTE_W-1:0] http_lit [PREFIX_LEN] = '{CHAR_H, CHAR_T, CHAR_T, CHAR_P, CHAR_SLASH};

  // Run statistics for the closing summary.
  int live_bytes     = 0;
  int restarts_seen  = 0;
  int lines_done     = 0;
  int lines_failed   = 0;
  int full_reasons   = 0;
  int stall_seen     = 0;
  int mismatch_cnt   = 0;

  // Result words still owed by the block, oldest first.
  status_word_t expected_words [$];

  // Idle rates of the two sides, in percent, and the one-shot hold request.
  int tx_idle_pct = 22;
  int rx_idle_pct = 61;
  bit hold_req    = 1'b0;

  // A version digit replaces the value when it is the first one and
  // accumulates otherwise; the value never exceeds its field.
  function automatic int add_version_digit(input int acc, input int pos, input int d);
    int v;
    v = (pos == 0) ? d : acc * 10 + d;
    return (v > VERSION_CAP) ? VERSION_CAP : v;
  endfunction

  // Advances the line model by one byte and returns the word the block must
  // produce for it.
  function automatic status_word_t parse_status_byte(input logic [BYTE_W-1:0] b,
                                                     input logic rs);
    status_word_t w;
    phase_t       was;
    bit           is_dig;
    bit           is_rchar;
    int           d;
    w        = '0;
    is_dig   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    is_rchar = (b == CHAR_HTAB) || ((b >= CHAR_SPACE) && (b <= CHAR_TILDE)) || (b > CHAR_DEL);
    d        = int'(b) - int'(CHAR_ZERO);
    // A restart clears everything before the byte itself is looked at.
    if (rs) begin
      line_phase = PH_PREFIX;
      field_pos  = 0;
      major_acc  = 0;
      minor_acc  = 0;
      code_acc   = 0;
      restarts_seen++;
    end
    was = line_phase;
    if (line_phase != PH_DONE && line_phase != PH_ERROR) live_bytes++;
    case (line_phase)
      PH_PREFIX: begin
        if (field_pos >= PREFIX_LEN || b != http_lit[field_pos]) begin
          line_phase = PH_ERROR;
        end else if (b == CHAR_SLASH) begin
          field_pos  = 0;
          line_phase = PH_MAJOR;
        end else begin
          field_pos++;
        end
      end
      // The separator is checked ahead of the digit count, so a version of
      // full length can still be closed.
      PH_MAJOR: begin
        if (b == CHAR_DOT) begin
          field_pos  = 0;
          line_phase = PH_MINOR;
        end else if (field_pos >= VERSION_DIGITS || !is_dig) begin
          line_phase = PH_ERROR;
        end else begin
          major_acc = add_version_digit(major_acc, field_pos, d);
          field_pos++;
        end
      end
      PH_MINOR: begin
        if (b == CHAR_SPACE) begin
          field_pos  = 0;
          line_phase = PH_CODE;
        end else if (field_pos >= VERSION_DIGITS || !is_dig) begin
          line_phase = PH_ERROR;
        end else begin
          minor_acc = add_version_digit(minor_acc, field_pos, d);
          field_pos++;
        end
      end
      // The status code takes exactly three digits and then a space.
      PH_CODE: begin
        if (field_pos >= CODE_DIGITS) begin
          if (b == CHAR_SPACE) begin
            field_pos  = 0;
            line_phase = PH_REASON;
          end else begin
            line_phase = PH_ERROR;
          end
        end else if (!is_dig) begin
          line_phase = PH_ERROR;
        end else begin
          code_acc = (field_pos == 0) ? d : ((code_acc * 10 + d) & 'h3FF);
          field_pos++;
        end
      end
      // CR always closes the phrase, even at full length.
      PH_REASON: begin
        if (b == CHAR_CR) begin
          field_pos  = 0;
          line_phase = PH_LF;
        end else if (field_pos >= MAX_REASON_LEN || !is_rchar) begin
          line_phase = PH_ERROR;
        end else begin
          w.rvalid = 1'b1;
          w.rbyte  = b;
          w.ridx   = RIDX_W'(field_pos);
          field_pos++;
          if (field_pos == MAX_REASON_LEN) full_reasons++;
        end
      end
      PH_LF: begin
        line_phase = (b == CHAR_LF) ? PH_DONE : PH_ERROR;
      end
      default: begin
      end
    endcase
    if (was != line_phase && line_phase == PH_DONE) lines_done++;
    if (was != line_phase && line_phase == PH_ERROR) lines_failed++;
    w.phase = line_phase;
    w.major = VER_W'(major_acc);
    w.minor = VER_W'(minor_acc);
    w.code  = CODE_W'(code_acc);
    return w;
  endfunction

  function automatic dir_row_t mk(input logic [BYTE_W-1:0] b, input logic rs);
    dir_row_t r;
    r.b     = b;
    r.rs    = rs;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic dir_row_t mk_t(input logic [BYTE_W-1:0] b, input logic rs,
                                    input phase_t ph, input int maj, input int mnr,
                                    input int code, input bit rv, input int rb,
                                    input int ri);
    dir_row_t r;
    r.b            = b;
    r.rs           = rs;
    r.typed        = 1'b1;
    r.want.phase   = ph;
    r.want.major   = VER_W'(maj);
    r.want.minor   = VER_W'(mnr);
    r.want.code    = CODE_W'(code);
    r.want.rvalid  = rv;
    r.want.rbyte   = BYTE_W'(rb);
    r.want.ridx    = RIDX_W'(ri);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Inputs change on the falling edge; a word counts as accepted
  // at the rising edge where ready is seen high while valid is held.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic rs, input bit typed,
                           input status_word_t want);
    status_word_t w;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.byte_in <= b;
    in_ch.restart <= rs;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    w = parse_status_byte(b, rs);
    expected_words.push_back(typed ? want : w);
  endtask

  // Bytes of the status line that is being assembled, with their restart flags.
  logic [BYTE_W-1:0] line_bytes [$];
  logic              line_rs [$];

  // The first byte of a line always carries the restart flag.
  task automatic push_item(input logic [BYTE_W-1:0] b);
    line_rs.push_back(line_bytes.size() == 0);
    line_bytes.push_back(b);
  endtask

  task automatic push_digits(input int n);
    for (int i = 0; i < n; i++) push_item(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
  endtask

  // Mostly printable text, with tabs, spaces and high bytes mixed in.
  task automatic push_reason(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      case (k)
        0:       push_item(CHAR_HTAB);
        1:       push_item(CHAR_SPACE);
        2:       push_item(BYTE_W'($urandom_range(8'h80, 8'hFF)));
        default: push_item(BYTE_W'($urandom_range(8'h21, 8'h7E)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side. The receiver drops ready at random, and once holds it low
  // for a long stretch so that both internal registers fill and the block
  // has to stall its input.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          if (in_ch.valid === 1'b1 && in_ch.ready === 1'b0) stall_seen++;
          @(negedge clk);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Every accepted result word is checked against the oldest one owed.
  always @(posedge clk) begin
    status_word_t got_w;
    status_word_t want_w;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_w.phase  = phase_t'(out_ch.parse_phase);
      got_w.major  = out_ch.major_ver;
      got_w.minor  = out_ch.minor_ver;
      got_w.code   = out_ch.resp_code;
      got_w.rvalid = out_ch.reason_valid;
      got_w.rbyte  = out_ch.reason_byte;
      got_w.ridx   = out_ch.reason_index;
      if (expected_words.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result word arrived with none outstanding: phase %0d", $realtime,
                   got_w.phase);
      end else begin
        want_w = expected_words.pop_front();
        if (got_w !== want_w) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: expected ph %0d maj %0d min %0d code %0d rsn %0b/%02h/%0d",
                     $realtime, want_w.phase, want_w.major, want_w.minor, want_w.code,
                     want_w.rvalid, want_w.rbyte, want_w.ridx);
            $display("%0t: actual   ph %0d maj %0d min %0d code %0d rsn %0b/%02h/%0d",
                     $realtime, got_w.phase, got_w.major, got_w.minor, got_w.code,
                     got_w.rvalid, got_w.rbyte, got_w.ridx);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random status lines, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t dir_table [$];
    int       rand_start;
    int       stage;
    int       kind;
    int       maj_n;
    int       min_n;
    int       code_n;
    int       rlen;
    int       cut;
    bit       broken;
    bit       corrupt;
    bit       hold_issued;

    in_ch.valid   = 1'b0;
    in_ch.byte_in = '0;
    in_ch.restart = 1'b0;
    hold_issued   = 1'b0;

    // Synchronous reset held low from the start and released on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: the largest version and code, an empty minor version,
    // the reason character extremes, done held against further bytes, a
    // restart straight into a bad prefix byte, and error held afterwards.
    dir_table.push_back(mk_t(CHAR_H, 1'b1, PH_PREFIX, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(mk(CHAR_T, 1'b0));
    dir_table.push_back(mk(CHAR_T, 1'b0));
    dir_table.push_back(mk(CHAR_P, 1'b0));
    dir_table.push_back(mk(CHAR_SLASH, 1'b0));
    dir_table.push_back(mk(CHAR_NINE, 1'b0));
    dir_table.push_back(mk_t(CHAR_NINE, 1'b0, PH_MAJOR, 99, 0, 0, 0, 0, 0));
    dir_table.push_back(mk(CHAR_DOT, 1'b0));
    dir_table.push_back(mk(CHAR_SPACE, 1'b0));
    dir_table.push_back(mk(CHAR_NINE, 1'b0));
    dir_table.push_back(mk(CHAR_NINE, 1'b0));
    dir_table.push_back(mk_t(CHAR_NINE, 1'b0, PH_CODE, 99, 0, 999, 0, 0, 0));
    dir_table.push_back(mk(CHAR_SPACE, 1'b0));
    dir_table.push_back(mk_t(8'hFF, 1'b0, PH_REASON, 99, 0, 999, 1, 8'hFF, 0));
    dir_table.push_back(mk(CHAR_HTAB, 1'b0));
    dir_table.push_back(mk(CHAR_CR, 1'b0));
    dir_table.push_back(mk(CHAR_LF, 1'b0));
    dir_table.push_back(mk_t(8'h00, 1'b0, PH_DONE, 99, 0, 999, 0, 0, 0));
    dir_table.push_back(mk_t(8'h00, 1'b1, PH_ERROR, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(mk_t(8'hFF, 1'b0, PH_ERROR, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(mk(CHAR_H, 1'b1));
    dir_table.push_back(mk_t(CHAR_SLASH, 1'b0, PH_ERROR, 0, 0, 0, 0, 0, 0));
    foreach (dir_table[i]) send_word(dir_table[i].b, dir_table[i].rs, dir_table[i].typed,
                                     dir_table[i].want);

    // Random part. Most lines are well formed with random content; the rest
    // break one rule each or are plain noise. The idle pattern moves through
    // three stages as the run goes on.
    rand_start = live_bytes;
    while (live_bytes - rand_start < RANDOM_BYTES) begin
      stage = (live_bytes - rand_start) * 3 / RANDOM_BYTES;
      if (stage > 2) stage = 2;
      case (stage)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 61;
        end
        1: begin
          tx_idle_pct = 61;
          rx_idle_pct = 22;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // The long hold-off happens once, while the sender keeps offering.
          if (!hold_issued) begin
            hold_req    = 1'b1;
            hold_issued = 1'b1;
          end
        end
      endcase

      line_bytes.delete();
      line_rs.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
        // Noise: random bytes with the odd restart in between.
        repeat ($urandom_range(1, 8)) begin
          line_rs.push_back(line_bytes.size() == 0 || $urandom_range(0, 9) == 0);
          line_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
      end else begin
        broken  = (kind >= 70);
        corrupt = 1'b0;
        maj_n   = $urandom_range(0, VERSION_DIGITS);
        min_n   = $urandom_range(0, VERSION_DIGITS);
        code_n  = CODE_DIGITS;
        rlen    = ($urandom_range(0, 4) == 0) ? $urandom_range(MAX_REASON_LEN - 6, MAX_REASON_LEN)
                                               : $urandom_range(0, 12);
        if (broken) begin
          case ($urandom_range(0, 4))
            0:       maj_n = VERSION_DIGITS + 1;
            1:       min_n = VERSION_DIGITS + 1;
            2:       code_n = $urandom_range(0, 1) ? CODE_DIGITS - 1 : CODE_DIGITS + 1;
            3:       rlen = $urandom_range(MAX_REASON_LEN + 1, MAX_REASON_LEN + 3);
            default: corrupt = 1'b1;
          endcase
        end
        foreach (http_lit[i]) push_item(http_lit[i]);
        push_digits(maj_n);
        push_item(CHAR_DOT);
        push_digits(min_n);
        push_item(CHAR_SPACE);
        push_digits(code_n);
        push_item(CHAR_SPACE);
        push_reason(rlen);
        push_item(CHAR_CR);
        push_item(CHAR_LF);
        if (corrupt) line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
          BYTE_W'($urandom_range(0, 255));
        // A broken line may also stop short; the next restart recovers it.
        if (broken && $urandom_range(0, 1) == 1) begin
          cut = $urandom_range(1, line_bytes.size());
          while (line_bytes.size() > cut) begin
            void'(line_bytes.pop_back());
            void'(line_rs.pop_back());
          end
        end
        // A few trailing bytes may follow the line; after done or error they leave the phase alone.
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) begin
          line_rs.push_back(1'b0);
          line_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
      end
      foreach (line_bytes[i]) send_word(line_bytes[i], line_rs[i], 1'b0, '0);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain every outstanding result, then keep watching the two-stage pipeline
    // for any word it should not produce.
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Parsed %0d live bytes after %0d restarts: %0d lines done, %0d in error,",
             live_bytes, restarts_seen, lines_done, lines_failed);
    $display("%0d full-length reasons; result side held off %0d cycles, input stalled on %0d.",
             full_reasons, HOLD_CYCLES, stall_seen);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
